### hdl/cts_pkg.sv
// cts_pkg: types, codes and helper functions for the token scanner
// used by cts_front, cts_back and c_like_token_scanner; no dependencies
package cts_pkg;

  localparam int unsigned MAX_TOKEN_LEN_DEF = 255;
  localparam int unsigned FIFO_DEPTH_DEF    = 4;

  // token kinds
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_END    = 3'd1;
  localparam logic [2:0] KIND_CHAR   = 3'd2;
  localparam logic [2:0] KIND_INT    = 3'd3;
  localparam logic [2:0] KIND_FLOAT  = 3'd4;
  localparam logic [2:0] KIND_STRING = 3'd5;
  localparam logic [2:0] KIND_DIV    = 3'd6;

  // integer suffix codes on the result
  localparam logic [2:0] SFX_NONE = 3'd0;
  localparam logic [2:0] SFX_LONG = 3'd1;
  localparam logic [2:0] SFX_UNS  = 3'd2;
  localparam logic [2:0] SFX_UL   = 3'd3;
  localparam logic [2:0] SFX_ULL  = 3'd4;

  // suffix progress while scanning
  localparam logic [2:0] SP_NONE = 3'd0;
  localparam logic [2:0] SP_L    = 3'd1;
  localparam logic [2:0] SP_LL   = 3'd2;
  localparam logic [2:0] SP_U    = 3'd3;
  localparam logic [2:0] SP_UL   = 3'd4;
  localparam logic [2:0] SP_ULL  = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SUFFIX  = 2'd1;
  localparam logic [1:0] ERR_NEWLINE = 2'd2;
  localparam logic [1:0] ERR_UNTERM  = 2'd3;

  // characters
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0_0000_0000_0001,
    M_NUMBER     = 13'b0_0000_0000_0010,
    M_SUFFIX     = 13'b0_0000_0000_0100,
    M_FLOAT      = 13'b0_0000_0000_1000,
    M_IDENT      = 13'b0_0000_0001_0000,
    M_SLASH      = 13'b0_0000_0010_0000,
    M_LINE_CMT   = 13'b0_0000_0100_0000,
    M_BLOCK_CMT  = 13'b0_0000_1000_0000,
    M_BLOCK_STAR = 13'b0_0001_0000_0000,
    M_CHAR       = 13'b0_0010_0000_0000,
    M_CHAR_ESC   = 13'b0_0100_0000_0000,
    M_STRING     = 13'b0_1000_0000_0000,
    M_STRING_ESC = 13'b1_0000_0000_0000
  } mode_e;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        end_of_input;
    logic [15:0] src_line;
    logic [11:0] src_column;
  } in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [2:0]  int_suffix;
    logic [15:0] start_line;
    logic [11:0] start_column;
    logic [7:0]  token_length;
    logic [1:0]  error_code;
    logic        last_of_run;
  } out_t;

  // up to two results caused by one input transaction
  typedef struct packed {
    logic two;
    out_t first;
    out_t second;
  } bundle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [2:0] sfx_code(logic [2:0] prog);
    logic [2:0] code;
    case (prog)
      SP_L, SP_LL: code = SFX_LONG;
      SP_U:        code = SFX_UNS;
      SP_UL:       code = SFX_UL;
      SP_ULL:      code = SFX_ULL;
      default:     code = SFX_NONE;
    endcase
    return code;
  endfunction

  function automatic out_t make_rec(logic [2:0] kind, logic [2:0] sfx, logic [1:0] err,
                                    logic [15:0] line, logic [11:0] col, logic [7:0] len);
    out_t r;
    r.token_kind   = kind;
    r.int_suffix   = sfx;
    r.start_line   = line;
    r.start_column = col;
    r.token_length = len;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

### hdl/cts_front.sv
// cts_front: scanner state machine, classifies each character and builds result bundles
// depends on cts_pkg
module cts_front import cts_pkg::*; #(
  parameter int unsigned MaxTokenLen = MAX_TOKEN_LEN_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  in_t     item_i,
  output logic    bundle_valid_o,
  output bundle_t bundle_o
);

  localparam logic [7:0] LenCap = 8'((MaxTokenLen < 255) ? MaxTokenLen : 255);

  mode_e       mode_q, mode_d;
  logic [15:0] line_q, line_d;
  logic [11:0] col_q, col_d;
  logic [7:0]  len_q, len_d;
  logic [2:0]  prog_q, prog_d;
  logic        bad_q, bad_d;
  logic        up_q, up_d;

  logic [7:0]  c;
  logic [7:0]  grown;
  logic        up;
  logic [7:0]  lc;
  logic [2:0]  fs_prog;
  logic        fs_bad;
  logic        fs_up;
  out_t        int_rec;
  out_t        tok;
  out_t        end_rec;
  logic        tok_valid;
  logic        do_start;
  logic [1:0]  end_err;

  assign c     = item_i.char_code;
  assign grown = (len_q < LenCap) ? len_q + 8'd1 : len_q;
  assign up    = is_upper(c);
  assign lc    = up ? c + CASE_GAP : c;

  assign int_rec = make_rec(KIND_INT, bad_q ? SFX_NONE : sfx_code(prog_q),
                            bad_q ? ERR_SUFFIX : ERR_NONE, line_q, col_q, len_q);

  // suffix letter check: l, ll, u, ul, ull in one case only
  always_comb begin
    fs_prog = prog_q;
    fs_bad  = bad_q;
    fs_up   = up_q;
    if (!bad_q) begin
      if (prog_q == SP_NONE) begin
        fs_up = up;
        if (lc == CH_LOW_L) begin
          fs_prog = SP_L;
        end else if (lc == CH_LOW_U) begin
          fs_prog = SP_U;
        end else begin
          fs_bad = 1'b1;
        end
      end else if ((up != up_q) || (lc != CH_LOW_L)) begin
        fs_bad = 1'b1;
      end else begin
        case (prog_q)
          SP_L:    fs_prog = SP_LL;
          SP_U:    fs_prog = SP_UL;
          SP_UL:   fs_prog = SP_ULL;
          default: fs_bad = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    len_d     = len_q;
    prog_d    = prog_q;
    bad_d     = bad_q;
    up_d      = up_q;
    tok_valid = 1'b0;
    tok       = make_rec(KIND_IDENT, SFX_NONE, ERR_NONE, line_q, col_q, len_q);
    do_start  = 1'b0;
    end_err   = ERR_NONE;

    if (item_i.end_of_input) begin
      case (mode_q)
        M_NUMBER, M_SUFFIX: begin
          tok_valid = 1'b1;
          tok       = int_rec;
        end
        M_FLOAT: begin
          tok_valid = 1'b1;
          tok       = make_rec(KIND_FLOAT, SFX_NONE, ERR_NONE, line_q, col_q, len_q);
        end
        M_IDENT: begin
          tok_valid = 1'b1;
        end
        M_SLASH: begin
          tok_valid = 1'b1;
          tok       = make_rec(KIND_DIV, SFX_NONE, ERR_NONE, line_q, col_q, len_q);
        end
        M_CHAR, M_CHAR_ESC: begin
          tok_valid = 1'b1;
          tok       = make_rec(KIND_CHAR, SFX_NONE, ERR_UNTERM, line_q, col_q, len_q);
        end
        M_STRING, M_STRING_ESC: begin
          tok_valid = 1'b1;
          tok       = make_rec(KIND_STRING, SFX_NONE, ERR_UNTERM, line_q, col_q, len_q);
        end
        M_BLOCK_CMT, M_BLOCK_STAR: begin
          end_err = ERR_UNTERM;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
    end else begin
      case (mode_q)
        M_NUMBER: begin
          if (is_digit(c)) begin
            len_d = grown;
          end else if (c == CH_DOT) begin
            len_d  = grown;
            mode_d = M_FLOAT;
          end else if (is_alpha(c)) begin
            len_d  = grown;
            prog_d = fs_prog;
            bad_d  = fs_bad;
            up_d   = fs_up;
            mode_d = M_SUFFIX;
          end else begin
            tok_valid = 1'b1;
            tok       = int_rec;
            do_start  = 1'b1;
          end
        end
        M_SUFFIX: begin
          if (is_alpha(c)) begin
            len_d  = grown;
            prog_d = fs_prog;
            bad_d  = fs_bad;
            up_d   = fs_up;
          end else begin
            tok_valid = 1'b1;
            tok       = int_rec;
            do_start  = 1'b1;
          end
        end
        M_FLOAT: begin
          if (is_digit(c)) begin
            len_d = grown;
          end else begin
            tok_valid = 1'b1;
            tok       = make_rec(KIND_FLOAT, SFX_NONE, ERR_NONE, line_q, col_q, len_q);
            do_start  = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
            len_d = grown;
          end else begin
            tok_valid = 1'b1;
            do_start  = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_d = M_LINE_CMT;
          end else if (c == CH_STAR) begin
            mode_d = M_BLOCK_CMT;
          end else begin
            tok_valid = 1'b1;
            tok       = make_rec(KIND_DIV, SFX_NONE, ERR_NONE, line_q, col_q, len_q);
            do_start  = 1'b1;
          end
        end
        M_LINE_CMT: begin
          if (c == CH_NL) mode_d = M_IDLE;
        end
        M_BLOCK_CMT: begin
          if (c == CH_STAR) mode_d = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          if (c == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (c != CH_STAR) begin
            mode_d = M_BLOCK_CMT;
          end
        end
        M_CHAR: begin
          len_d = grown;
          if (c == CH_BSLASH) begin
            mode_d = M_CHAR_ESC;
          end else if (c == CH_SQUOTE) begin
            tok_valid = 1'b1;
            tok       = make_rec(KIND_CHAR, SFX_NONE, ERR_NONE, line_q, col_q, grown);
            mode_d    = M_IDLE;
          end
        end
        M_CHAR_ESC: begin
          len_d  = grown;
          mode_d = M_CHAR;
        end
        M_STRING: begin
          if (c == CH_NL) begin
            // string cut at the newline, newline not counted
            tok_valid = 1'b1;
            tok       = make_rec(KIND_STRING, SFX_NONE, ERR_NEWLINE, line_q, col_q, len_q);
            mode_d    = M_IDLE;
          end else begin
            len_d = grown;
            if (c == CH_BSLASH) begin
              mode_d = M_STRING_ESC;
            end else if (c == CH_DQUOTE) begin
              tok_valid = 1'b1;
              tok       = make_rec(KIND_STRING, SFX_NONE, ERR_NONE, line_q, col_q, grown);
              mode_d    = M_IDLE;
            end
          end
        end
        M_STRING_ESC: begin
          len_d  = grown;
          mode_d = M_STRING;
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      // the character that ended a token is scanned again from idle
      if (do_start) begin
        line_d = item_i.src_line;
        col_d  = item_i.src_column;
        len_d  = 8'd1;
        prog_d = SP_NONE;
        bad_d  = 1'b0;
        up_d   = 1'b0;
        if (is_digit(c)) begin
          mode_d = M_NUMBER;
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
          mode_d = M_IDENT;
        end else if (c == CH_SLASH) begin
          mode_d = M_SLASH;
        end else if (c == CH_SQUOTE) begin
          mode_d = M_CHAR;
        end else if (c == CH_DQUOTE) begin
          mode_d = M_STRING;
        end else begin
          mode_d = M_IDLE;
          len_d  = 8'd0;
        end
      end
    end
  end

  assign end_rec = make_rec(KIND_END, SFX_NONE, end_err, item_i.src_line,
                            item_i.src_column, 8'd0);

  always_comb begin
    if (item_i.end_of_input) begin
      bundle_valid_o  = 1'b1;
      bundle_o.two    = tok_valid;
      bundle_o.first  = tok_valid ? tok : end_rec;
      bundle_o.second = end_rec;
    end else begin
      bundle_valid_o  = tok_valid;
      bundle_o.two    = 1'b0;
      bundle_o.first  = tok;
      bundle_o.second = tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      line_q <= '0;
      col_q  <= '0;
      len_q  <= '0;
      prog_q <= SP_NONE;
      bad_q  <= 1'b0;
      up_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
      len_q  <= len_d;
      prog_q <= prog_d;
      bad_q  <= bad_d;
      up_q   <= up_d;
    end
  end

`ifndef SYNTH
  a_eof_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.end_of_input) |-> bundle_valid_o)
    else $error("end of input produced no result");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenCap)
    else $error("held token length above cap");
`endif

endmodule

### hdl/cts_fifo.sv
// cts_fifo: short queue of result bundles between scanner and output side
// depends on nothing outside this file
module cts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
`endif

endmodule

### hdl/cts_back.sv
// cts_back: output side, hands out the records of each queued bundle one by one
// depends on cts_pkg
module cts_back import cts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bundle_t head_i,
  input  logic    head_valid_i,
  output logic    head_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output out_t    result_o
);

  logic idx_q, idx_d;
  logic take;

  assign empty_o = !head_valid_i;
  assign take    = pop_i && head_valid_i;

  always_comb begin
    result_o             = idx_q ? head_i.second : head_i.first;
    result_o.last_of_run = idx_q || !head_i.two;
  end

  // a two-record bundle stays at the head for the first transaction
  always_comb begin
    idx_d      = idx_q;
    head_pop_o = 1'b0;
    if (take) begin
      if (head_i.two && !idx_q) begin
        idx_d = 1'b1;
      end else begin
        idx_d      = 1'b0;
        head_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTH
  a_second_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (head_valid_i && head_i.two))
    else $error("second record selected without a two-record bundle");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop_o |-> head_valid_i)
    else $error("bundle released from an empty queue");
`endif

endmodule

### hdl/c_like_token_scanner.sv
// c_like_token_scanner: character scanner producing token records; depends on cts_pkg
// a completing character's bundle enters the queue as the character is accepted
// throughput: one character per cycle while not full; end of input with an open token
// gives two results, popped one at a time; the FifoDepth-entry bundle queue sets full
// reset (async, active low) puts the scanner in idle and empties the queue
module c_like_token_scanner import cts_pkg::*; #(
  parameter int unsigned MaxTokenLen = MAX_TOKEN_LEN_DEF,
  parameter int unsigned FifoDepth   = FIFO_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  item_i,
  output logic empty,
  input  logic pop,
  output out_t result_o
);

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle;
  bundle_t head;
  logic    head_pop;
  logic    fifo_empty;
  logic    fifo_full;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  cts_front #(
    .MaxTokenLen(MaxTokenLen)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (item_i),
    .bundle_valid_o(bundle_valid),
    .bundle_o      (bundle)
  );

  cts_fifo #(
    .Width($bits(bundle_t)),
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && bundle_valid),
    .wdata_i(bundle),
    .pop_i  (head_pop),
    .rdata_o(head),
    .full_o (fifo_full),
    .empty_o(fifo_empty)
  );

  cts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(!fifo_empty),
    .head_pop_o  (head_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule
